[design/pcw_pkg.sv]
// Package for the Philox counter word core: constants and pipeline types.
`timescale 1ns / 1ps
`default_nettype none

package pcw_pkg;

    // Number of Philox rounds, one pipeline stage each
    localparam int ROUND_COUNT = 10;
    // Round stages plus the word-select output stage
    localparam int STAGES = ROUND_COUNT + 1;
    // Width of an occupancy count that can hold STAGES
    localparam int OCC_W = $clog2(STAGES + 1);

    localparam logic [31:0] MUL_A  = 32'hD251_1F53;
    localparam logic [31:0] MUL_B  = 32'hCD9E_8D57;
    localparam logic [31:0] WEYL_A = 32'h9E37_79B9;
    localparam logic [31:0] WEYL_B = 32'hBB67_AE85;

    // Counter block in flight plus the word it will hand out
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [1:0]  sel;
    } blk_t;

endpackage

`default_nettype wire

[design/philox_counter_word_core.sv]
// Top level: pipelined Philox4x32 generator returning one 32-bit word per index.
// Throughput: one index per cycle while the output is not stalled;
// each round owns a stage with its two multipliers.
// Stalls back up stage by stage; empty stages keep filling while the output waits.
// Reset clears all stage valid bits and loads the round keys for a zero key.
// Round keys are precomputed into registers when the key is written.
`timescale 1ns / 1ps
`default_nettype none

module philox_counter_word_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // key configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] seed_key,
    // index input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] draw_index,
    // word output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      random_word
);

    localparam int RC = pcw_pkg::ROUND_COUNT;
    localparam int ST = pcw_pkg::STAGES;

    logic [31:0]   rk_a_reg [RC];
    logic [31:0]   rk_b_reg [RC];
    logic [ST-1:0] vld_reg;
    logic [ST-1:0] vld_next;
    logic [ST:0]   rdy;
    pcw_pkg::blk_t stage_blk [RC];
    pcw_pkg::blk_t in_blk;
    logic [31:0]   word_reg;
    logic [31:0]   word_next;

    // Key port never stalls
    assign cfg_ready = 1'b1;

    // Round key schedule, one register pair per round
    for (genvar r = 0; r < RC; r++)
    begin : g_key
        localparam logic [63:0] OFS_A_W = 64'(r) * {32'h0, pcw_pkg::WEYL_A};
        localparam logic [63:0] OFS_B_W = 64'(r) * {32'h0, pcw_pkg::WEYL_B};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rk_a_reg[r] <= OFS_A_W[31:0];
                rk_b_reg[r] <= OFS_B_W[31:0];
            end
            else if (cfg_valid && cfg_ready)
            begin
                rk_a_reg[r] <= seed_key[31:0] + OFS_A_W[31:0];
                rk_b_reg[r] <= seed_key[63:32] + OFS_B_W[31:0];
            end
        end
    end

    // Ready chain: a stage loads when empty or when its content moves on
    always_comb
    begin
        rdy[ST] = out_ready;
        for (int i = ST - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    // Valid bits travel with the data
    always_comb
    begin
        for (int i = 0; i < ST; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Initial counter block from the index
    always_comb
    begin
        in_blk.w0  = draw_index[33:2];
        in_blk.w1  = {2'b00, draw_index[63:34]};
        in_blk.w2  = 32'h0;
        in_blk.w3  = 32'h0;
        in_blk.sel = draw_index[1:0];
    end

    // Round stages
    for (genvar r = 0; r < RC; r++)
    begin : g_round
        pcw_round u_round (
            .clk     (clk),
            .load    (rdy[r]),
            .blk_in  ((r == 0) ? in_blk : stage_blk[(r == 0) ? 0 : r - 1]),
            .key_a   (rk_a_reg[r]),
            .key_b   (rk_b_reg[r]),
            .blk_reg (stage_blk[r])
        );
    end

    // Output stage: pick the requested word of the final block
    always_comb
    begin
        case (stage_blk[RC-1].sel)
            2'd0:    word_next = stage_blk[RC-1].w0;
            2'd1:    word_next = stage_blk[RC-1].w1;
            2'd2:    word_next = stage_blk[RC-1].w2;
            2'd3:    word_next = stage_blk[RC-1].w3;
            default: word_next = stage_blk[RC-1].w0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST-1])
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid   = vld_reg[ST-1];
    assign random_word = word_reg;

    // Transactions in flight, for checking only
    logic [pcw_pkg::OCC_W-1:0] occ_reg;
    logic [pcw_pkg::OCC_W-1:0] occ_next;

    always_comb
    begin
        occ_next = occ_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Every accepted transaction sits in exactly one stage until delivered
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == pcw_pkg::OCC_W'($countones(vld_reg)))
        else $error("pipeline valid bits disagree with transactions in flight");

    // An empty first stage must always take input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> in_ready)
        else $error("input stalled with first stage empty");

    // A stalled output stage keeps its valid bit
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && occ_reg != '0))
        else $error("stalled output lost");

endmodule

`default_nettype wire

[design/pcw_round.sv]
// One registered Philox4x32 round: two 32x32 products, permute, key XOR.
`timescale 1ns / 1ps
`default_nettype none

module pcw_round (
    input  wire logic         clk,
    input  wire logic         load,
    input  wire pcw_pkg::blk_t blk_in,
    input  wire logic [31:0]  key_a,
    input  wire logic [31:0]  key_b,
    output pcw_pkg::blk_t     blk_reg
);

    logic [63:0]   prod_a;
    logic [63:0]   prod_b;
    pcw_pkg::blk_t blk_next;

    // Full-width products of words 0 and 2
    assign prod_a = {32'h0, pcw_pkg::MUL_A} * {32'h0, blk_in.w0};
    assign prod_b = {32'h0, pcw_pkg::MUL_B} * {32'h0, blk_in.w2};

    // Permute product halves and mix in the round key
    always_comb
    begin
        blk_next.w0  = prod_b[63:32] ^ blk_in.w1 ^ key_a;
        blk_next.w1  = prod_b[31:0];
        blk_next.w2  = prod_a[63:32] ^ blk_in.w3 ^ key_b;
        blk_next.w3  = prod_a[31:0];
        blk_next.sel = blk_in.sel;
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            blk_reg <= blk_next;
        end
    end

endmodule

`default_nettype wire
